// ===== design/sfd_pkg.sv =====
// Shared types and constants for the serial frame decoder.
`default_nettype none
package sfd_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;  // frame bytes 1..23
  localparam int NUM_CHANNELS  = 16;
  localparam int CH_BITS       = 11;
  localparam int NUM_RESULTS   = NUM_CHANNELS + 2;
  localparam int IDX_W         = 5;
  localparam int Q_DEPTH       = 2;

  localparam logic [7:0] SYNC_BYTE   = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'h00;
  localparam logic [7:0] LIMIT_RESET = 8'd50;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;

  // Result kinds
  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // Result indexes of the two flag bits and of the final result
  localparam logic [IDX_W-1:0] FLAG_HI_IDX = IDX_W'(NUM_CHANNELS);
  localparam logic [IDX_W-1:0] FLAG_LO_IDX = IDX_W'(NUM_CHANNELS + 1);

  // One request from the front to the back: a decoded frame or a timeout
  typedef struct packed {
    logic                         timeout;
    logic [PAYLOAD_BYTES*8-1:0]   frame;
  } sfd_req_t;

endpackage
`default_nettype wire

// ===== design/sfd_front.sv =====
// Byte window, attempt counter and frame / timeout detection.
`default_nettype none
module sfd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            q_full,
  output logic                 q_push,
  output sfd_pkg::sfd_req_t    q_req
);
  import sfd_pkg::*;

  logic [7:0] win_r [FRAME_BYTES];
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] limit_r;
  logic       accept;
  logic       is_frame;
  logic       is_timeout;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Classify the byte against the window as it will stand after the shift
  always_comb begin
    cnt_nxt    = (cnt_r == COUNT_MAX) ? COUNT_MAX : cnt_r + 8'd1;
    is_frame   = (win_r[1] == SYNC_BYTE) && (in_rx_byte == END_BYTE);
    is_timeout = !is_frame && (cnt_nxt >= limit_r);
  end

  // Build the request from frame bytes 1..23 of the shifted window
  always_comb begin
    q_req.timeout = is_timeout;
    for (int k = 0; k < PAYLOAD_BYTES - 1; k++) begin
      q_req.frame[8*k +: 8] = win_r[k+2];
    end
    q_req.frame[8*(PAYLOAD_BYTES-1) +: 8] = win_r[FRAME_BYTES-1];
  end

  assign q_push = accept && (is_frame || is_timeout);

  // Hold the attempt limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // Shift the window, or clear it when an attempt ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) win_r[i] <= '0;
    end else if (accept) begin
      if (is_frame || is_timeout) begin
        cnt_r <= '0;
        for (int i = 0; i < FRAME_BYTES; i++) win_r[i] <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        for (int i = 0; i < FRAME_BYTES - 1; i++) win_r[i] <= win_r[i+1];
        win_r[FRAME_BYTES-1] <= in_rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sfd_queue.sv =====
// Short request queue between detection and result expansion.
`default_nettype none
module sfd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sfd_pkg::sfd_req_t  push_req,
  output logic                    full,
  input  wire logic               pop,
  output sfd_pkg::sfd_req_t       pop_req,
  output logic                    empty
);
  import sfd_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  sfd_req_t            mem_r [Q_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [PTR_W:0]      cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_req = mem_r[rd_ptr_r];

  // Store requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/sfd_back.sv =====
// Expands each request into its result items, one per cycle while the receiver does not stall.
`default_nettype none
module sfd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire sfd_pkg::sfd_req_t  q_req,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_kind,
  output logic [4:0]              out_channel_index,
  output logic [10:0]             out_channel_value,
  output logic                    out_last
);
  import sfd_pkg::*;

  sfd_req_t            cur_r;
  logic                busy_r;
  logic [IDX_W-1:0]    idx_r;
  logic                out_valid_r;
  logic                kind_r;
  logic [IDX_W-1:0]    oidx_r;
  logic [CH_BITS-1:0]  val_r;
  logic                last_r;

  logic                advance;
  logic                res_kind;
  logic [IDX_W-1:0]    res_idx;
  logic [CH_BITS-1:0]  res_val;
  logic                res_last;
  logic [CH_BITS-1:0]  chan [NUM_CHANNELS];
  logic [7:0]          flag_byte;

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_channel_index = oidx_r;
  assign out_channel_value = val_r;
  assign out_last          = last_r;

  // Slice the frame into channel values
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan[c] = cur_r.frame[c*CH_BITS +: CH_BITS];
    end
    flag_byte = cur_r.frame[8*(PAYLOAD_BYTES-1) +: 8];
  end

  // Form the result for the current position
  always_comb begin
    res_kind = KIND_CHANNEL;
    res_idx  = idx_r;
    res_val  = '0;
    res_last = 1'b0;
    if (cur_r.timeout) begin
      res_kind = KIND_TIMEOUT;
      res_idx  = '0;
      res_last = 1'b1;
    end else if (idx_r == FLAG_HI_IDX) begin
      res_val = CH_BITS'(flag_byte[7]);
    end else if (idx_r == FLAG_LO_IDX) begin
      res_val  = CH_BITS'(flag_byte[6]);
      res_last = 1'b1;
    end else begin
      res_val = chan[idx_r[3:0]];
    end
  end

  assign advance = busy_r && (!out_valid_r || !out_stall);
  assign q_pop   = !q_empty && (!busy_r || (advance && res_last));

  // Load requests and step through their results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (advance) begin
      busy_r <= !res_last;
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_req;
    end
  end

  // Hold the result register until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= res_kind;
      oidx_r <= res_idx;
      val_r  <= res_val;
      last_r <= res_last;
    end
  end

endmodule
`default_nettype wire

// ===== design/sbus_frame_decoder.sv =====
// Top level of the serial frame decoder.
//
// Usage:
//   in_*  : one received byte per request (in_valid / in_stall).
//   out_* : result requests (out_valid / out_stall). A decoded frame gives
//           18 results: channels 0..15 (11 bits each), then flag bits 7 and
//           6 of frame byte 23 at indexes 16 and 17, the last with out_last.
//           An attempt that reaches the limit without a frame gives one
//           timeout result (kind 1, index 0, value 0, last 1).
//   cfg_* : writes the attempt limit; cfg_ready is always high.
// Throughput: one byte per cycle while in_stall is low. A byte that ends a
//   frame gives 18 results in the expansion stage; a timeout gives one. A
//   two-entry request queue sits between detection and expansion, and
//   in_stall rises only when that queue is full.
// Path to the first result of a request: the queue entry, the request load
//   into expansion, then the result register.
// Reset: window and counter clear, limit returns to 50, the queue empties.
// A stalled receiver holds the output register; the rest backs up into the
//   queue and then stalls the input.
`default_nettype none
module sbus_frame_decoder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_rx_byte,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_kind,
  output logic [4:0]        out_channel_index,
  output logic [10:0]       out_channel_value,
  output logic              out_last,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data
);
  import sfd_pkg::*;

  sfd_req_t push_req;
  sfd_req_t pop_req;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_req      (push_req)
  );

  sfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .empty    (q_empty)
  );

  sfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_req             (pop_req),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
